// ----- sv/paps_pkg.sv -----
// Package for the precedence-aware priority insert sort block.
// Types and constants shared by the RAM user, the top level and the checker.
package paps_pkg;
  localparam int MaxTasks = 32;
  localparam int MaxEmit = 32;
  localparam int IdxW = $clog2(MaxTasks);
  localparam int LenW = $clog2(MaxTasks + 1);
  localparam int SlotW = 5 + 16 + 8 + 17;

  typedef struct packed {
    logic [4:0] id;
    logic [15:0] deadline;
    logic [7:0] weight;
    logic signed [16:0] remaining;
  } slot_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_SHIFT, ST_PLACE, ST_EMIT_RD, ST_EMIT
  } state_t;

  function automatic logic beats(slot_t a, slot_t b);
    if (a.deadline != b.deadline) return a.deadline < b.deadline;
    if (a.weight != b.weight) return a.weight > b.weight;
    return a.remaining > b.remaining;
  endfunction
endpackage

// ----- sv/precedence_aware_priority_insert_sort.sv -----
// Top level: precedence-aware priority insertion sort over a slot RAM.
// Depends on paps_pkg and paps_ram.
// Insert: the new task scans the list for its prerequisites, then moves past
// the entries it beats down to the last prerequisite; a lost compare stops it.
// Then it is written into its slot. One item is taken at a time, and no new
// one until it is placed; scan and shift share the one RAM read port.
// Emission: a read of slot 0, then one result per RAM read, output registered.
// Reset clears list length, overflow flag and control; the RAM is not cleared.
module precedence_aware_priority_insert_sort import paps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [4:0]  in_task_id,
  input  logic [15:0] in_deadline,
  input  logic [7:0]  in_weight,
  input  logic [15:0] in_required_work,
  input  logic [15:0] in_completed_work,
  input  logic [31:0] in_prereq_mask,
  input  logic        in_last_task,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_rank,
  output logic [4:0]  out_ordered_id,
  output logic        out_final_entry,
  output logic        out_overflowed
);
  state_t state_r, state_nxt;
  logic [LenW-1:0] len_r, len_nxt, pos_r, pos_nxt, cnt_r, cnt_nxt;
  logic [LenW:0] bnd_r, bnd_nxt;        // boundary + 1
  logic ovf_r, ovf_nxt, last_r, last_nxt;
  logic [31:0] seen_r, seen_nxt, mask_r;
  slot_t task_r;
  logic rd_pend_r, rd_pend_nxt;

  logic we;
  logic [IdxW-1:0] waddr, raddr;
  slot_t wdata, rdata;
  logic [SlotW-1:0] rdata_raw;
  logic [LenW-1:0] emit_cnt;

  paps_ram #(.Width(SlotW), .Depth(MaxTasks)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata_raw));
  assign rdata = slot_t'(rdata_raw);

  assign in_ready = (state_r == ST_IDLE);
  assign emit_cnt = (len_r > LenW'(MaxEmit)) ? LenW'(MaxEmit) : len_r;

  // output register
  logic ov_r, ov_nxt;
  logic [4:0] rank_r, id_r;
  logic fin_r, ovo_r;
  assign out_valid = ov_r;
  assign out_rank = rank_r;
  assign out_ordered_id = id_r;
  assign out_final_entry = fin_r;
  assign out_overflowed = ovo_r;
  logic out_load;

  always_comb begin
    state_nxt = state_r;
    len_nxt = len_r; pos_nxt = pos_r; cnt_nxt = cnt_r; bnd_nxt = bnd_r;
    ovf_nxt = ovf_r; last_nxt = last_r; seen_nxt = seen_r;
    rd_pend_nxt = 1'b0;
    case (state_r)
      ST_IDLE: if (in_valid) begin
        last_nxt = in_last_task;
        seen_nxt = '0; bnd_nxt = '0; cnt_nxt = '0; pos_nxt = len_r;
        if (len_r >= LenW'(MaxTasks)) begin
          ovf_nxt = 1'b1;
          state_nxt = in_last_task ? ST_EMIT_RD : ST_IDLE;
        end else begin
          state_nxt = ST_SCAN;
          rd_pend_nxt = (len_r != '0);
        end
      end
      ST_SCAN: begin
        // rd_pend_r: rdata holds slot cnt_r
        if (rd_pend_r) begin
          if (mask_r[rdata.id] && !seen_r[rdata.id]) begin
            seen_nxt = seen_r | (32'd1 << rdata.id);
            bnd_nxt = (LenW+1)'(cnt_r) + 1'b1;
          end
          cnt_nxt = cnt_r + 1'b1;
        end
        if (rd_pend_r ? (cnt_r + 1'b1 < len_r) : 1'b0) rd_pend_nxt = 1'b1;
        else if (!rd_pend_r || cnt_r + 1'b1 >= len_r) begin
          state_nxt = ST_SHIFT;
          rd_pend_nxt = ((LenW+1)'(pos_r) > bnd_nxt);
        end
      end
      ST_SHIFT: begin
        // rdata holds slot pos_r-1 when rd_pend_r
        if (rd_pend_r && beats(task_r, rdata)) begin
          pos_nxt = pos_r - 1'b1;
          state_nxt = ST_SHIFT;
          rd_pend_nxt = 1'b0;
        end else begin
          state_nxt = ST_PLACE;
        end
        if (rd_pend_r && beats(task_r, rdata)) begin
          // after moving, read next neighbor
          rd_pend_nxt = ((LenW+1)'(pos_r - 1'b1) > bnd_r);
          if (!rd_pend_nxt) state_nxt = ST_PLACE;
        end
      end
      ST_PLACE: begin
        len_nxt = len_r + 1'b1;
        state_nxt = last_r ? ST_EMIT_RD : ST_IDLE;
        cnt_nxt = '0;
      end
      ST_EMIT_RD: begin
        if (emit_cnt == '0) begin
          len_nxt = '0; ovf_nxt = 1'b0; state_nxt = ST_IDLE;
        end else begin
          rd_pend_nxt = 1'b1; cnt_nxt = '0; state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        rd_pend_nxt = rd_pend_r;
        if (out_load) begin
          cnt_nxt = cnt_r + 1'b1;
          rd_pend_nxt = 1'b0;
          if (cnt_r + 1'b1 == emit_cnt) begin
            len_nxt = '0; ovf_nxt = 1'b0; state_nxt = ST_IDLE;
          end
        end else if (!rd_pend_r) rd_pend_nxt = 1'b1;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // RAM port control
  always_comb begin
    we = 1'b0; waddr = pos_r[IdxW-1:0]; wdata = task_r; raddr = '0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE: raddr = '0;
      // last scan cycle issues the first shift read of slot pos_r-1
      ST_SCAN: raddr = (state_nxt == ST_SHIFT) ? IdxW'(pos_r - 1'b1)
                                               : IdxW'(cnt_r + 1'b1);
      ST_SHIFT: begin
        raddr = IdxW'(pos_nxt - 1'b1);
        if (rd_pend_r && beats(task_r, rdata)) begin
          we = 1'b1; waddr = pos_r[IdxW-1:0]; wdata = rdata;
        end
      end
      ST_PLACE: we = 1'b1;
      ST_EMIT_RD: raddr = '0;
      ST_EMIT: begin
        raddr = IdxW'(cnt_r);
        out_load = rd_pend_r && (!ov_r || out_ready);
        if (out_load) raddr = IdxW'(cnt_r + 1'b1);
      end
      default: raddr = '0;
    endcase
  end

  always_comb ov_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : ov_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; len_r <= '0; ovf_r <= 1'b0; ov_r <= 1'b0;
      rd_pend_r <= 1'b0; pos_r <= '0; cnt_r <= '0; bnd_r <= '0;
      last_r <= 1'b0; seen_r <= '0;
    end else begin
      state_r <= state_nxt; len_r <= len_nxt; ovf_r <= ovf_nxt;
      ov_r <= ov_nxt; rd_pend_r <= rd_pend_nxt; pos_r <= pos_nxt;
      cnt_r <= cnt_nxt; bnd_r <= bnd_nxt; last_r <= last_nxt;
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      task_r.id <= in_task_id;
      task_r.deadline <= in_deadline;
      task_r.weight <= in_weight;
      task_r.remaining <= $signed({1'b0, in_required_work})
                        - $signed({1'b0, in_completed_work});
      mask_r <= in_prereq_mask;
    end
    if (out_load) begin
      rank_r <= cnt_r[4:0];
      id_r <= rdata.id;
      fin_r <= (cnt_r + 1'b1 == emit_cnt);
      ovo_r <= ovf_r;
    end
  end
endmodule

// ----- sv/paps_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module paps_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- sv/paps_checker.sv -----
// Port-level checker for the precedence-aware priority insert sort block.
// Depends on paps_pkg; bound to the top level.
module paps_checker import paps_pkg::*; (
  input logic clk, rst_n, in_valid, in_ready, out_valid, out_ready,
  input logic [4:0] out_rank, input logic out_final_entry
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rank)) else $error("hold");
  a_rank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_final_entry ##1 out_valid
    |-> out_rank == $past(out_rank) + 5'd1) else $error("rank");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_final_entry |-> !in_ready) else $error("busy");
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid) else $error("in hold");
endmodule

bind precedence_aware_priority_insert_sort paps_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_rank(out_rank),
  .out_final_entry(out_final_entry));

// ----- test/tb_precedence_aware_priority_insert_sort.sv -----
// Testbench for precedence_aware_priority_insert_sort: directed and random task batches
// against a scoreboard holding its own copy of the task list. Needs paps_pkg.
`timescale 1ns / 100ps

module tb_precedence_aware_priority_insert_sort;
  import paps_pkg::*;

  typedef struct packed {
    logic [4:0] rank;
    logic [4:0] id;
    logic       fin;
    logic       ovf;
  } order_entry_t;

  class order_board;
    logic [4:0]         ids[MaxTasks];
    logic [15:0]        dls[MaxTasks];
    logic [7:0]         wts[MaxTasks];
    logic signed [16:0] rems[MaxTasks];
    int unsigned        len;
    bit                 ovf;
    order_entry_t       pending[$];
    int                 errors;

    function automatic bit wins(logic [15:0] da, logic [7:0] wa, logic signed [16:0] ra,
                                int j);
      if (da != dls[j]) return da < dls[j];
      if (wa != wts[j]) return wa > wts[j];
      return ra > rems[j];
    endfunction

    function void note_task(logic [4:0] id, logic [15:0] dl, logic [7:0] wt,
                            logic [15:0] req, logic [15:0] done,
                            logic [31:0] mask, bit last);
      logic signed [16:0] rem;
      logic [31:0] seen;
      int pos, bound, n;
      order_entry_t e;
      rem = $signed({1'b0, req}) - $signed({1'b0, done});
      seen = '0;
      bound = -1;
      if (len >= MaxTasks) ovf = 1;
      else begin
        pos = len;
        for (int i = 0; i < pos; i++)
          if (mask[ids[i]] && !seen[ids[i]]) begin
            seen[ids[i]] = 1'b1;
            bound = i;
          end
        while (pos > bound + 1 && wins(dl, wt, rem, pos - 1)) begin
          ids[pos] = ids[pos-1]; dls[pos] = dls[pos-1];
          wts[pos] = wts[pos-1]; rems[pos] = rems[pos-1];
          pos--;
        end
        ids[pos] = id; dls[pos] = dl; wts[pos] = wt; rems[pos] = rem;
        len++;
      end
      if (last) begin
        n = (len > MaxEmit) ? MaxEmit : len;
        for (int k = 0; k < n; k++) begin
          e.rank = k[4:0]; e.id = ids[k]; e.fin = (k + 1 == n); e.ovf = ovf;
          pending.insert(pending.size(), e);
        end
        len = 0;
        ovf = 0;
      end
    endfunction

    function void check_entry(order_entry_t got);
      order_entry_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected entry %p", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: entry mismatch expected %p actual %p", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic [4:0] in_task_id = 0;
  logic [15:0] in_deadline = 0, in_required_work = 0, in_completed_work = 0;
  logic [7:0] in_weight = 0;
  logic [31:0] in_prereq_mask = 0;
  logic in_last_task = 0;
  logic [4:0] out_rank, out_ordered_id;
  logic out_final_entry, out_overflowed;

  order_board board = new();
  int send_idle = 0, recv_stall = 0, quiet = 0;
  bit [4:0] batch_ids[$];

  precedence_aware_priority_insert_sort dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_entry({out_rank, out_ordered_id, out_final_entry, out_overflowed});
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
    else quiet++;
    if (quiet > 20000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall);

  // valid is dropped only while idling, so back-to-back items keep it high
  task automatic send_task(bit [4:0] id, bit [15:0] dl, bit [7:0] wt, bit [15:0] req,
                           bit [15:0] done, bit [31:0] mask, bit last);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1; in_task_id <= id; in_deadline <= dl; in_weight <= wt;
    in_required_work <= req; in_completed_work <= done;
    in_prereq_mask <= mask; in_last_task <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_task(id, dl, wt, req, done, mask, last);
    @(negedge clk);
  endtask

  // mostly prerequisites drawn from ids already sent in this batch
  task automatic random_batch(int n);
    bit [31:0] mask;
    bit [4:0] id;
    for (int i = 0; i < n; i++) begin
      mask = 0;
      if ($urandom_range(9) == 0) mask = $urandom();
      else if (batch_ids.size() > 0)
        repeat ($urandom_range(2)) mask[batch_ids[$urandom_range(batch_ids.size() - 1)]] = 1;
      id = ($urandom_range(7) == 0) ? 5'($urandom()) : i[4:0];
      batch_ids.insert(batch_ids.size(), id);
      send_task(id, 16'($urandom_range(3) == 0 ? $urandom() : $urandom_range(4)),
                8'($urandom_range(1) ? $urandom() : $urandom_range(2)),
                16'($urandom()), $urandom_range(1) ? 16'($urandom()) : 16'd100,
                mask, i == n - 1);
    end
    batch_ids.delete();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1;
    // directed: extremes, ties, negative remaining, duplicates, missing prereq
    send_task(5'd0, 16'hFFFF, 8'd0, 16'd0, 16'hFFFF, 32'h0, 0);
    send_task(5'd31, 16'd0, 8'hFF, 16'hFFFF, 16'd0, 32'h0, 0);
    send_task(5'd1, 16'd0, 8'hFF, 16'd5, 16'd0, 32'h0, 0);
    send_task(5'd2, 16'd0, 8'hFF, 16'd0, 16'd1, 32'h8000_0000, 0);
    send_task(5'd1, 16'd0, 8'hFF, 16'hFFFF, 16'd0, 32'h0000_0002, 0);
    send_task(5'd3, 16'd0, 8'd0, 16'd0, 16'd0, 32'hFFFF_FFFF, 0);
    send_task(5'd4, 16'd0, 8'hFF, 16'd9, 16'd0, 32'h0000_0400, 1);
    send_task(5'd7, 16'd3, 8'd3, 16'd3, 16'd3, 32'h0, 1);
    // overflow: 33 tasks, last one dropped but still ends the batch
    for (int i = 0; i < 33; i++)
      send_task(i[4:0], ~i[15:0], 8'd0, 16'd0, 16'd0, 32'h0, i == 32);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? 61 : 0;
      recv_stall = (ph == 2 || ph == 3) ? 61 : 0;
      if (ph == 3) begin send_idle = 10; recv_stall = 10; end
      repeat (8) random_batch($urandom_range(1, 10));
    end
    random_batch(32);
    random_batch(34);
    in_valid <= 0;
    while (board.pending.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
